// ===== src/ghd_pkg.sv =====
// Shared types and constants for the gyro handling detector.
// No dependencies; used by ghd_isqrt and gyro_handling_detector.
`default_nettype none

package ghd_pkg;

	localparam int unsigned ENERGY_W  = 24;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned RATE_W    = 16;
	localparam int unsigned SQSUM_W   = 32;
	localparam int unsigned ROOT_W    = 16;
	localparam int unsigned COEF_W    = 16;
	localparam int unsigned PROD_W    = ENERGY_W + COEF_W;
	localparam int unsigned IN_DATA_W  = 88;
	localparam int unsigned OUT_DATA_W = 32;
	localparam int unsigned ADDR_W    = 5;

	localparam logic [TIME_W-1:0] SAMPLE_GAP_MS      = 32'd40;
	localparam logic [TIME_W-1:0] FIRE_COOLDOWN_MS   = 32'd3000;
	localparam logic [TIME_W-1:0] SPEECH_COOLDOWN_MS = 32'd15000;

	// Q0.16 coefficients, truncated
	localparam logic [COEF_W-1:0] COEF_KEEP  = 16'd52428;
	localparam logic [COEF_W-1:0] COEF_NEW   = 16'd13107;
	localparam logic [COEF_W-1:0] COEF_DECAY = 16'd45875;

	localparam logic [ENERGY_W-1:0] ENERGY_MAX = 24'hFFFFFF;

	localparam logic [3:0] SENS_MIN   = 4'd1;
	localparam logic [3:0] SENS_MAX   = 4'd10;
	localparam logic [3:0] SENS_RESET = 4'd5;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_SENSOR_PRESENT = 3'd0;
	localparam logic [2:0] REG_ENABLE         = 3'd1;
	localparam logic [2:0] REG_SENSITIVITY    = 3'd2;
	localparam logic [2:0] REG_SPEAK_ON_TRIG  = 3'd3;
	localparam logic [2:0] REG_HAS_PHRASES    = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GATE,
		ST_DECAY,
		ST_DECAY_WB,
		ST_MUL_X,
		ST_MUL_Y,
		ST_MUL_Z,
		ST_SUM_Z,
		ST_ROOT_GO,
		ST_ROOT_WAIT,
		ST_KEEP,
		ST_NEW,
		ST_ADD,
		ST_CHECK,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		MS_NONE,
		MS_SQ_X,
		MS_SQ_Y,
		MS_SQ_Z,
		MS_KEEP,
		MS_NEW,
		MS_DECAY
	} mul_sel_t;

	typedef struct packed {
		logic     in_ready;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     sqrt_start;
	} ctl_t;

	// Trigger threshold in energy units: (285 - 25*level) << 12
	function automatic logic [ENERGY_W-1:0] threshold(input logic [3:0] level);
		logic [8:0] dps;
		dps = 9'd285 - (9'(level) * 9'd25);
		return {3'b000, dps, 12'h000};
	endfunction

endpackage

`default_nettype wire

// ===== src/ghd_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on ghd_pkg for widths.
`default_nettype none

module ghd_isqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [ghd_pkg::SQSUM_W-1:0]   radicand,
	output logic                               done,
	output logic      [ghd_pkg::ROOT_W-1:0]    root
);

	localparam int unsigned REM_W = ghd_pkg::ROOT_W + 1;
	localparam int unsigned CNT_W = $clog2(ghd_pkg::ROOT_W);

	logic                         busy_q;
	logic                         done_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [ghd_pkg::SQSUM_W-1:0]  rad_q;
	logic [REM_W-1:0]             rem_q;
	logic [ghd_pkg::ROOT_W-1:0]   root_q;

	logic [REM_W+1:0]             rem_sh;
	logic [REM_W+1:0]             trial;
	logic                         fits;

	always_comb begin
		rem_sh = {rem_q, rad_q[ghd_pkg::SQSUM_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		fits   = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ghd_pkg::ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[ghd_pkg::SQSUM_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= REM_W'(rem_sh - trial);
				root_q <= {root_q[ghd_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[REM_W-1:0];
				root_q <= {root_q[ghd_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

// ===== src/gyro_handling_detector.sv =====
// Gyro handling detector: gates timestamped gyro samples, low-passes motion
// energy and fires a reaction. Depends on ghd_pkg and ghd_isqrt.
//
// Usage:
//  Input beats arrive on s_axis_* (one sample each), one result beat per input
//  beat leaves on m_axis_*. Settings are written over the APB port while idle.
//  A sample is held in the block while one 24x16 multiplier and a bit-serial
//  square root work on it; s_axis_tready is high only in the idle state.
//  A skipped or disabled sample goes from the gate state to the output state;
//  a decay-only sample passes the decay states; a full filter update runs the
//  squares, the square root iterations and the filter update steps.
//  A new sample is taken only once the last result is in the output register.
//  The result sits in an output register: the next sample is accepted while
//  it waits, and that sample's result is held back until the register is
//  taken, so a stalled receiver stalls the input after at most one sample.
//  Reset clears energy, all timestamps and the output valid flag and loads the
//  default settings (sensor present, enabled, sensitivity 5, speak on
//  trigger, phrases available).
`default_nettype none

module gyro_handling_detector (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// now_ms[31:0], rate_x[47:32], rate_y[63:48], rate_z[79:64], rate_ok[80],
	// camera_busy[81], gesture_active[82], speaking[83], ai_mode[84],
	// offline[85], zero pad[87:86]
	input  wire logic [ghd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// sample_taken[0], fired[1], speak_request[2], energy_level[26:3],
	// zero pad[31:27]
	output logic      [ghd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [ghd_pkg::ADDR_W-1:0]       paddr,
	input  wire logic [31:0]                      pwdata,
	output logic      [31:0]                      prdata,
	output logic                                  pready
);

	localparam int unsigned EW = ghd_pkg::ENERGY_W;
	localparam int unsigned TW = ghd_pkg::TIME_W;
	localparam int unsigned RW = ghd_pkg::RATE_W;

	// configuration
	logic       sensor_present_q;
	logic       enable_q;
	logic [3:0] sensitivity_q;
	logic       speak_on_trig_q;
	logic       has_phrases_q;

	logic       cfg_wr;
	logic [2:0] cfg_idx;
	logic [3:0] sens_clamped;

	// state
	logic [TW-1:0] last_sample_q;
	logic [TW-1:0] last_fire_q;
	logic [TW-1:0] last_speech_q;
	logic [EW-1:0] energy_q;

	// held sample
	logic [TW-1:0] now_q;
	logic [RW-1:0] abs_x_q;
	logic [RW-1:0] abs_y_q;
	logic [RW-1:0] abs_z_q;
	logic          rate_ok_q;
	logic          camera_busy_q;
	logic          gesture_q;
	logic          speaking_q;
	logic          ai_mode_q;
	logic          offline_q;

	// work registers
	logic [ghd_pkg::PROD_W-1:0]  prod_q;
	logic [ghd_pkg::SQSUM_W-1:0] sum_q;
	logic [EW:0]                 acc_q;
	logic [ghd_pkg::ROOT_W-1:0]  root_q;
	logic                        taken_q;
	logic                        fired_q;
	logic                        speak_q;

	// output register
	logic                           m_valid_q;
	logic [ghd_pkg::OUT_DATA_W-1:0] m_data_q;

	ghd_pkg::state_t state_q;
	ghd_pkg::state_t state_d;
	ghd_pkg::ctl_t   ctl;

	logic                        in_accept;
	logic                        out_load;
	logic                        gate_ok;
	logic [EW-1:0]               mul_a;
	logic [ghd_pkg::COEF_W-1:0]  mul_b;
	logic                        sqrt_done;
	logic [ghd_pkg::ROOT_W-1:0]  sqrt_root;
	logic [EW-1:0]               e_sat;
	logic                        fire_ok;
	logic                        speak_ok;

	function automatic logic [RW-1:0] abs16(input logic [RW-1:0] v);
		return v[RW-1] ? RW'(~v + 1'b1) : v;
	endfunction

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[ghd_pkg::ADDR_W-1:2];

	always_comb begin
		sens_clamped = pwdata[3:0];
		if (sens_clamped < ghd_pkg::SENS_MIN) begin
			sens_clamped = ghd_pkg::SENS_MIN;
		end
		if (sens_clamped > ghd_pkg::SENS_MAX) begin
			sens_clamped = ghd_pkg::SENS_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_present_q <= 1'b1;
			enable_q         <= 1'b1;
			sensitivity_q    <= ghd_pkg::SENS_RESET;
			speak_on_trig_q  <= 1'b1;
			has_phrases_q    <= 1'b1;
		end else if (cfg_wr) begin
			case (cfg_idx)
				ghd_pkg::REG_SENSOR_PRESENT: sensor_present_q <= pwdata[0];
				ghd_pkg::REG_ENABLE:         enable_q         <= pwdata[0];
				ghd_pkg::REG_SENSITIVITY:    sensitivity_q    <= sens_clamped;
				ghd_pkg::REG_SPEAK_ON_TRIG:  speak_on_trig_q  <= pwdata[0];
				ghd_pkg::REG_HAS_PHRASES:    has_phrases_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			ghd_pkg::REG_SENSOR_PRESENT: prdata = {31'd0, sensor_present_q};
			ghd_pkg::REG_ENABLE:         prdata = {31'd0, enable_q};
			ghd_pkg::REG_SENSITIVITY:    prdata = {28'd0, sensitivity_q};
			ghd_pkg::REG_SPEAK_ON_TRIG:  prdata = {31'd0, speak_on_trig_q};
			ghd_pkg::REG_HAS_PHRASES:    prdata = {31'd0, has_phrases_q};
			default:                     prdata = 32'd0;
		endcase
	end

	// ---------------- sequencer ----------------
	assign in_accept = s_axis_tvalid && ctl.in_ready;
	assign out_load  = (state_q == ghd_pkg::ST_OUT) && (!m_valid_q || m_axis_tready);
	assign gate_ok   = sensor_present_q && !camera_busy_q
		&& ((now_q - last_sample_q) >= ghd_pkg::SAMPLE_GAP_MS);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ghd_pkg::ST_IDLE: begin
				if (in_accept) state_d = ghd_pkg::ST_GATE;
			end
			ghd_pkg::ST_GATE: begin
				if (!gate_ok || !enable_q) begin
					state_d = ghd_pkg::ST_OUT;
				end else if (gesture_q || speaking_q) begin
					state_d = ghd_pkg::ST_DECAY;
				end else if (rate_ok_q) begin
					state_d = ghd_pkg::ST_MUL_X;
				end else begin
					state_d = ghd_pkg::ST_OUT;
				end
			end
			ghd_pkg::ST_DECAY:     state_d = ghd_pkg::ST_DECAY_WB;
			ghd_pkg::ST_DECAY_WB:  state_d = ghd_pkg::ST_OUT;
			ghd_pkg::ST_MUL_X:     state_d = ghd_pkg::ST_MUL_Y;
			ghd_pkg::ST_MUL_Y:     state_d = ghd_pkg::ST_MUL_Z;
			ghd_pkg::ST_MUL_Z:     state_d = ghd_pkg::ST_SUM_Z;
			ghd_pkg::ST_SUM_Z:     state_d = ghd_pkg::ST_ROOT_GO;
			ghd_pkg::ST_ROOT_GO:   state_d = ghd_pkg::ST_ROOT_WAIT;
			ghd_pkg::ST_ROOT_WAIT: begin
				if (sqrt_done) state_d = ghd_pkg::ST_KEEP;
			end
			ghd_pkg::ST_KEEP:      state_d = ghd_pkg::ST_NEW;
			ghd_pkg::ST_NEW:       state_d = ghd_pkg::ST_ADD;
			ghd_pkg::ST_ADD:       state_d = ghd_pkg::ST_CHECK;
			ghd_pkg::ST_CHECK:     state_d = ghd_pkg::ST_OUT;
			ghd_pkg::ST_OUT: begin
				if (out_load) state_d = ghd_pkg::ST_IDLE;
			end
			default:               state_d = ghd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.in_ready   = 1'b0;
		ctl.mul_en     = 1'b0;
		ctl.mul_sel    = ghd_pkg::MS_NONE;
		ctl.sqrt_start = 1'b0;
		case (state_q)
			ghd_pkg::ST_IDLE:    ctl.in_ready   = 1'b1;
			ghd_pkg::ST_DECAY: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = ghd_pkg::MS_DECAY;
			end
			ghd_pkg::ST_MUL_X: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = ghd_pkg::MS_SQ_X;
			end
			ghd_pkg::ST_MUL_Y: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = ghd_pkg::MS_SQ_Y;
			end
			ghd_pkg::ST_MUL_Z: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = ghd_pkg::MS_SQ_Z;
			end
			ghd_pkg::ST_ROOT_GO: ctl.sqrt_start = 1'b1;
			ghd_pkg::ST_KEEP: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = ghd_pkg::MS_KEEP;
			end
			ghd_pkg::ST_NEW: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = ghd_pkg::MS_NEW;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ghd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_axis_tready = ctl.in_ready;

	// ---------------- shared multiplier ----------------
	always_comb begin
		case (ctl.mul_sel)
			ghd_pkg::MS_SQ_X: begin
				mul_a = EW'(abs_x_q);
				mul_b = abs_x_q;
			end
			ghd_pkg::MS_SQ_Y: begin
				mul_a = EW'(abs_y_q);
				mul_b = abs_y_q;
			end
			ghd_pkg::MS_SQ_Z: begin
				mul_a = EW'(abs_z_q);
				mul_b = abs_z_q;
			end
			ghd_pkg::MS_KEEP: begin
				mul_a = energy_q;
				mul_b = ghd_pkg::COEF_KEEP;
			end
			ghd_pkg::MS_NEW: begin
				mul_a = {root_q, 8'h00};
				mul_b = ghd_pkg::COEF_NEW;
			end
			ghd_pkg::MS_DECAY: begin
				mul_a = energy_q;
				mul_b = ghd_pkg::COEF_DECAY;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= ghd_pkg::PROD_W'(mul_a) * ghd_pkg::PROD_W'(mul_b);
		end
	end

	ghd_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.sqrt_start),
		.radicand (sum_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// ---------------- datapath ----------------
	always_comb begin
		e_sat    = acc_q[EW] ? ghd_pkg::ENERGY_MAX : acc_q[EW-1:0];
		fire_ok  = (e_sat > ghd_pkg::threshold(sensitivity_q)) && ai_mode_q
			&& ((now_q - last_fire_q) >= ghd_pkg::FIRE_COOLDOWN_MS);
		speak_ok = speak_on_trig_q && has_phrases_q && !offline_q
			&& ((now_q - last_speech_q) > ghd_pkg::SPEECH_COOLDOWN_MS);
	end

	// held sample and scratch values
	always_ff @(posedge clk) begin
		if (in_accept) begin
			now_q         <= s_axis_tdata[31:0];
			abs_x_q       <= abs16(s_axis_tdata[47:32]);
			abs_y_q       <= abs16(s_axis_tdata[63:48]);
			abs_z_q       <= abs16(s_axis_tdata[79:64]);
			rate_ok_q     <= s_axis_tdata[80];
			camera_busy_q <= s_axis_tdata[81];
			gesture_q     <= s_axis_tdata[82];
			speaking_q    <= s_axis_tdata[83];
			ai_mode_q     <= s_axis_tdata[84];
			offline_q     <= s_axis_tdata[85];
		end
		case (state_q)
			ghd_pkg::ST_MUL_Y: sum_q <= prod_q[ghd_pkg::SQSUM_W-1:0];
			ghd_pkg::ST_MUL_Z: sum_q <= sum_q + prod_q[ghd_pkg::SQSUM_W-1:0];
			ghd_pkg::ST_SUM_Z: sum_q <= sum_q + prod_q[ghd_pkg::SQSUM_W-1:0];
			ghd_pkg::ST_NEW:   acc_q <= {1'b0, prod_q[ghd_pkg::PROD_W-1 -: EW]};
			ghd_pkg::ST_ADD:   acc_q <= acc_q + {1'b0, prod_q[ghd_pkg::PROD_W-1 -: EW]};
			default: ;
		endcase
		if (sqrt_done) begin
			root_q <= sqrt_root;
		end
	end

	// persistent state and per-sample flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q <= '0;
			last_fire_q   <= '0;
			last_speech_q <= '0;
			energy_q      <= '0;
			taken_q       <= 1'b0;
			fired_q       <= 1'b0;
			speak_q       <= 1'b0;
		end else begin
			case (state_q)
				ghd_pkg::ST_IDLE: begin
					if (in_accept) begin
						taken_q <= 1'b0;
						fired_q <= 1'b0;
						speak_q <= 1'b0;
					end
				end
				ghd_pkg::ST_GATE: begin
					if (gate_ok) begin
						taken_q       <= 1'b1;
						last_sample_q <= now_q;
						// speech restarts the fire cooldown unless a gesture wins
						if (enable_q && !gesture_q && speaking_q) begin
							last_fire_q <= now_q;
						end
					end
				end
				ghd_pkg::ST_DECAY_WB: energy_q <= prod_q[ghd_pkg::PROD_W-1 -: EW];
				ghd_pkg::ST_CHECK: begin
					if (fire_ok) begin
						fired_q     <= 1'b1;
						last_fire_q <= now_q;
						energy_q    <= '0;
						if (speak_ok) begin
							speak_q       <= 1'b1;
							last_speech_q <= now_q;
						end
					end else begin
						energy_q <= e_sat;
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {5'd0, energy_q, speak_q, fired_q, taken_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// ---------------- assertions ----------------
	a_fire_needs_take: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
		else $error("fired without a taken sample");

	a_speak_needs_fire: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1])
		else $error("speak request without a fire");

	a_fire_clears: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[26:3] == '0)
		else $error("energy not cleared on fire");

	a_sens_range: assert property (@(posedge clk) disable iff (!arst_n)
		sensitivity_q >= ghd_pkg::SENS_MIN && sensitivity_q <= ghd_pkg::SENS_MAX)
		else $error("sensitivity out of range");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second sample accepted while busy");

endmodule

`default_nettype wire
